// ===== design/assert_macros.svh =====
// Assertion helpers for the checker of this project.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising edge, off during reset.
`define AWDS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled at the rising edge, off during reset.
`define AWDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/awds_pkg.sv =====
package awds_pkg;

	// Fixed field widths of the ports.
	localparam int CODE_BITS      = 16;
	localparam int INDEX_OUT_BITS = 16;
	localparam int VALUE_BITS     = 50;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 48;

	// Character codes recognized by the parser.
	localparam logic [7:0] CHAR_NUL  = 8'd0;
	localparam logic [7:0] CHAR_LF   = 8'd10;
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_NINE = 8'd57;

	// Saturation limits of the scaled values.
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_HEADER_SKIP = 3'd0,
		CFG_Y_REFERENCE = 3'd1,
		CFG_Y_INCREMENT = 3'd2,
		CFG_Y_ORIGIN    = 3'd3,
		CFG_X_REFERENCE = 3'd4,
		CFG_X_INCREMENT = 3'd5,
		CFG_X_ORIGIN    = 3'd6
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [3:0]  HEADER_SKIP_RST = 4'd10;
	localparam logic [31:0] INCREMENT_RST   = 32'd65536;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [3:0]  header_skip;
		logic [15:0] y_reference;
		logic [31:0] y_increment;
		logic [47:0] y_origin;
		logic [15:0] x_reference;
		logic [31:0] x_increment;
		logic [47:0] x_origin;
	} cfg_t;

	// Load enables of the two scaling stages.
	typedef struct packed {
		logic mul;
		logic sum;
	} pipe_en_t;

endpackage

// ===== design/awds_char_if.sv =====
interface awds_char_if import awds_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

// ===== design/awds_sample_if.sv =====
interface awds_sample_if import awds_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CODE_BITS-1:0]      sample_code;
	logic [INDEX_OUT_BITS-1:0] point_index;
	logic [VALUE_BITS-1:0]     voltage_value;
	logic [VALUE_BITS-1:0]     time_value;
	logic                      overflow;
	logic                      last;

	modport source (output valid, output sample_code, output point_index,
		output voltage_value, output time_value, output overflow, output last,
		input ready);
	modport sink (input valid, input sample_code, input point_index,
		input voltage_value, input time_value, input overflow, input last,
		output ready);
endinterface

// ===== design/awds_cfg_if.sv =====
interface awds_cfg_if import awds_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/awds_cfg_regs.sv =====
module awds_cfg_regs import awds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	awds_cfg_if.sink    cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	// Writes are always accepted.
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	// Register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.header_skip <= HEADER_SKIP_RST;
			regs_q.y_reference <= '0;
			regs_q.y_increment <= INCREMENT_RST;
			regs_q.y_origin    <= '0;
			regs_q.x_reference <= '0;
			regs_q.x_increment <= INCREMENT_RST;
			regs_q.x_origin    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_HEADER_SKIP: regs_q.header_skip <= cfg.data[3:0];
				CFG_Y_REFERENCE: regs_q.y_reference <= cfg.data[15:0];
				CFG_Y_INCREMENT: regs_q.y_increment <= cfg.data[31:0];
				CFG_Y_ORIGIN:    regs_q.y_origin    <= cfg.data[47:0];
				CFG_X_REFERENCE: regs_q.x_reference <= cfg.data[15:0];
				CFG_X_INCREMENT: regs_q.x_increment <= cfg.data[31:0];
				CFG_X_ORIGIN:    regs_q.x_origin    <= cfg.data[47:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/awds_parse.sv =====
module awds_parse import awds_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int INDEX_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   load,
	input  logic [7:0]             char_byte,
	input  logic [3:0]             header_skip,
	output logic                   valid_s1,
	output logic [SAMPLE_BITS-1:0] code_s1,
	output logic [INDEX_BITS-1:0]  index_s1,
	output logic                   overflow_s1,
	output logic                   last_s1
);

	logic [3:0]             header_count_q;
	logic [SAMPLE_BITS-1:0] acc_q;
	logic                   overflow_q;
	logic [INDEX_BITS-1:0]  counter_q;

	logic                   in_header;
	logic                   is_digit;
	logic                   is_end;
	logic                   emit;
	logic [3:0]             digit;
	logic [SAMPLE_BITS+3:0] acc_next;
	logic                   saturate;

	// Classify the byte.
	assign in_header = header_count_q < header_skip;
	assign is_digit  = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
	assign is_end    = (char_byte == CHAR_NUL) || (char_byte == CHAR_LF);
	assign emit      = !in_header && !is_digit;
	assign digit     = 4'(char_byte - CHAR_ZERO);

	// Decimal accumulate as acc * 8 + acc * 2 + digit, saturating.
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (SAMPLE_BITS+4)'(digit);
	assign saturate = acc_next[SAMPLE_BITS+3:SAMPLE_BITS] != 4'd0;

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			acc_q          <= '0;
			overflow_q     <= 1'b0;
			counter_q      <= '0;
		end else if (accept) begin
			if (in_header) begin
				header_count_q <= header_count_q + 4'd1;
			end else if (is_digit) begin
				acc_q      <= saturate ? '1 : acc_next[SAMPLE_BITS-1:0];
				overflow_q <= overflow_q | saturate;
			end else begin
				acc_q      <= '0;
				overflow_q <= 1'b0;
				if (is_end) begin
					counter_q      <= '0;
					header_count_q <= '0;
				end else begin
					counter_q <= counter_q + INDEX_BITS'(1);
				end
			end
		end
	end

	// Stage 1 valid: a word finished by this byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= accept && emit;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (load && accept && emit) begin
			code_s1     <= acc_q;
			index_s1    <= counter_q;
			overflow_s1 <= overflow_q;
			last_s1     <= is_end;
		end
	end

endmodule

// ===== design/awds_scale.sv =====
module awds_scale import awds_pkg::*; #(
	parameter int A_BITS = 16
) (
	input  logic                  clk,
	input  pipe_en_t              en,
	input  logic [A_BITS-1:0]     a,
	input  logic [15:0]           a_ref,
	input  logic [31:0]           inc,
	input  logic [47:0]           org,
	output logic [VALUE_BITS-1:0] value_q
);

	localparam int DW = ((A_BITS > 16) ? A_BITS : 16) + 1;
	localparam int PW = DW + 32;
	localparam int SW = ((PW > 48) ? PW : 48) + 1;

	logic signed [DW-1:0] diff;
	logic signed [31:0]   inc_s;
	logic signed [47:0]   org_s;
	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] prod_s2;
	logic signed [SW-1:0] sum_c;
	logic [SW-VALUE_BITS:0] sum_hi;
	logic [VALUE_BITS-1:0]  value_c;

	// Offset and multiply.
	assign inc_s  = $signed(inc);
	assign diff   = $signed(DW'(a)) - $signed(DW'(a_ref));
	assign prod_c = PW'(diff) * PW'(inc_s);

	always_ff @(posedge clk) begin
		if (en.mul) begin
			prod_s2 <= prod_c;
		end
	end

	// Add origin and saturate to the output range.
	assign org_s  = $signed(org);
	assign sum_c  = SW'(prod_s2) + SW'(org_s);
	assign sum_hi = sum_c[SW-1:VALUE_BITS-1];

	always_comb begin
		if ((sum_hi == '0) || (sum_hi == '1)) begin
			value_c = sum_c[VALUE_BITS-1:0];
		end else if (sum_c[SW-1]) begin
			value_c = VALUE_MIN;
		end else begin
			value_c = VALUE_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en.sum) begin
			value_q <= value_c;
		end
	end

endmodule

// ===== design/ascii_waveform_decode_scale_core.sv =====
// ASCII waveform decoder and scaler. One byte is accepted per clock on
// char_in while it is ready; after the programmed number of header bytes,
// decimal digits are accumulated and every other byte closes a sample, which
// passes the stage 1, multiply and output registers to sample_out with its
// code, index, and voltage and time scaled in Q.16. The parser state updates
// on every accepted byte, so the rate is one byte per cycle unless sample_out
// stalls; the three stages are parse, one 17x32 multiplier per axis at
// the default widths, and origin add with saturation into the output register.
// NUL or LF also ends the block and rearms the header skip. Configuration
// writes are never stalled and must be made only while no sample is in flight.
module ascii_waveform_decode_scale_core import awds_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int INDEX_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	awds_char_if.sink      char_in,
	awds_sample_if.source  sample_out,
	awds_cfg_if.sink       cfg
);

	cfg_t     regs;
	pipe_en_t en;

	logic adv1;
	logic adv2;
	logic adv3;
	logic accept;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] code_s1;
	logic [INDEX_BITS-1:0]  index_s1;
	logic                   overflow_s1;
	logic                   last_s1;

	logic                   valid_s2;
	logic [SAMPLE_BITS-1:0] code_s2;
	logic [INDEX_BITS-1:0]  index_s2;
	logic                   overflow_s2;
	logic                   last_s2;

	logic                      out_valid_q;
	logic [CODE_BITS-1:0]      code_q;
	logic [INDEX_OUT_BITS-1:0] index_q;
	logic                      overflow_q;
	logic                      last_q;
	logic [VALUE_BITS-1:0]     voltage_q;
	logic [VALUE_BITS-1:0]     time_q;

	// Each stage moves when the one after it is empty or moving.
	assign adv3    = !out_valid_q || sample_out.ready;
	assign adv2    = !valid_s2 || adv3;
	assign adv1    = !valid_s1 || adv2;
	assign en.mul  = adv2;
	assign en.sum  = adv3;
	assign accept  = char_in.valid && adv1;
	assign char_in.ready = adv1;

	awds_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	awds_parse #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.INDEX_BITS  (INDEX_BITS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.load        (adv1),
		.char_byte   (char_in.char_byte),
		.header_skip (regs.header_skip),
		.valid_s1    (valid_s1),
		.code_s1     (code_s1),
		.index_s1    (index_s1),
		.overflow_s1 (overflow_s1),
		.last_s1     (last_s1)
	);

	awds_scale #(.A_BITS(SAMPLE_BITS)) u_scale_y (
		.clk     (clk),
		.en      (en),
		.a       (code_s1),
		.a_ref   (regs.y_reference),
		.inc     (regs.y_increment),
		.org     (regs.y_origin),
		.value_q (voltage_q)
	);

	awds_scale #(.A_BITS(INDEX_BITS)) u_scale_x (
		.clk     (clk),
		.en      (en),
		.a       (index_s1),
		.a_ref   (regs.x_reference),
		.inc     (regs.x_increment),
		.org     (regs.x_origin),
		.value_q (time_q)
	);

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Side-band fields travel alongside the scaling stages.
	always_ff @(posedge clk) begin
		if (adv2) begin
			code_s2     <= code_s1;
			index_s2    <= index_s1;
			overflow_s2 <= overflow_s1;
			last_s2     <= last_s1;
		end
		if (adv3) begin
			code_q     <= CODE_BITS'(code_s2);
			index_q    <= INDEX_OUT_BITS'(index_s2);
			overflow_q <= overflow_s2;
			last_q     <= last_s2;
		end
	end

	assign sample_out.valid         = out_valid_q;
	assign sample_out.sample_code   = code_q;
	assign sample_out.point_index   = index_q;
	assign sample_out.voltage_value = voltage_q;
	assign sample_out.time_value    = time_q;
	assign sample_out.overflow      = overflow_q;
	assign sample_out.last          = last_q;

endmodule

// ===== design/awds_checker.sv =====
`include "assert_macros.svh"

module awds_checker import awds_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [CODE_BITS-1:0]  sample_code,
	input logic [VALUE_BITS-1:0] voltage_value,
	input logic                  overflow
);

	localparam logic [CODE_BITS-1:0] CODE_SAT = CODE_BITS'({SAMPLE_BITS{1'b1}});

	// A stalled word stays offered.
	`AWDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// A stalled word keeps its payload.
	`AWDS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(sample_code) && $stable(voltage_value))

	// With the output register empty the whole pipe can advance.
	`AWDS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

	// A saturated sample carries the largest code.
	`AWDS_ASSERT_NOW(a_overflow_code, out_valid && overflow, sample_code == CODE_SAT)

endmodule

bind ascii_waveform_decode_scale_core awds_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_awds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (char_in.ready),
	.out_valid     (sample_out.valid),
	.out_ready     (sample_out.ready),
	.sample_code   (sample_out.sample_code),
	.voltage_value (sample_out.voltage_value),
	.overflow      (sample_out.overflow)
);

// ===== bench/ascii_waveform_decode_scale_core_tb.sv =====
module ascii_waveform_decode_scale_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import awds_pkg::*;

	// Separator used by well-formed replies, and the one index with no register.
	localparam logic [7:0] CHAR_COMMA = 8'd44;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;
	localparam int PIPE_SETTLE = 8;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic [CODE_BITS-1:0]      code;
		logic [INDEX_OUT_BITS-1:0] index;
		logic [VALUE_BITS-1:0]     volt;
		logic [VALUE_BITS-1:0]     tval;
		logic                      ovf;
		logic                      last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n;

	awds_char_if   char_in();
	awds_sample_if sample_out();
	awds_cfg_if    cfg();

	ascii_waveform_decode_scale_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.sample_out (sample_out),
		.cfg        (cfg)
	);

	// Shadow copy of the decoder: registers and parse state.
	cfg_t        active_cfg;
	logic [3:0]  hdr_seen;
	logic [15:0] code_acc;
	logic        code_ovf;
	logic [15:0] point_count;

	sample_t pending_samples[$];
	int      error_count;
	int      body_items;
	int      sink_wait;
	bit      src_idle_on;
	bit      sink_idle_on;

	always #6 clk = ~clk;

	function automatic int draw_gap(bit enabled);
		return enabled ? $urandom_range(0, 18) : 0;
	endfunction

	// (point - reference) * increment + origin, clamped to the 50-bit output range.
	function automatic logic [VALUE_BITS-1:0] scale_value(logic [15:0] point,
		logic [15:0] ref_pt, logic [31:0] inc, logic [47:0] org);
		longint diff;
		longint prod;
		longint sum;
		longint lim_hi;
		longint lim_lo;
		lim_hi = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
		lim_lo = -lim_hi - 1;
		diff = longint'(point) - longint'(ref_pt);
		prod = diff * longint'(signed'(inc));
		if (prod > 2 * lim_hi) prod = 2 * lim_hi;
		if (prod < 2 * lim_lo) prod = 2 * lim_lo;
		sum = prod + longint'(signed'(org));
		if (sum > lim_hi) sum = lim_hi;
		if (sum < lim_lo) sum = lim_lo;
		return sum[VALUE_BITS-1:0];
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
		logic [CFG_DATA_BITS-1:0] d);
		case (idx)
			CFG_HEADER_SKIP: active_cfg.header_skip = d[3:0];
			CFG_Y_REFERENCE: active_cfg.y_reference = d[15:0];
			CFG_Y_INCREMENT: active_cfg.y_increment = d[31:0];
			CFG_Y_ORIGIN:    active_cfg.y_origin    = d[47:0];
			CFG_X_REFERENCE: active_cfg.x_reference = d[15:0];
			CFG_X_INCREMENT: active_cfg.x_increment = d[31:0];
			CFG_X_ORIGIN:    active_cfg.x_origin    = d[47:0];
			default: ;
		endcase
	endfunction

	// Advance the shadow parser by one byte and queue the sample it closes, if any.
	function automatic void decode_char(logic [7:0] c);
		sample_t     s;
		int unsigned nxt;
		logic        blk_end;
		if (hdr_seen < active_cfg.header_skip) begin
			hdr_seen = hdr_seen + 4'd1;
			return;
		end
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			nxt = 32'(code_acc);
			nxt = nxt * 10 + 32'(c - CHAR_ZERO);
			if (nxt > 32'hffff) begin
				nxt = 32'hffff;
				code_ovf = 1'b1;
			end
			code_acc = nxt[15:0];
			return;
		end
		blk_end = (c == CHAR_NUL) || (c == CHAR_LF);
		s.code = code_acc;
		s.index = point_count;
		s.volt = scale_value(code_acc, active_cfg.y_reference, active_cfg.y_increment,
			active_cfg.y_origin);
		s.tval = scale_value(point_count, active_cfg.x_reference, active_cfg.x_increment,
			active_cfg.x_origin);
		s.ovf = code_ovf;
		s.last = blk_end;
		pending_samples.push_back(s);
		code_acc = '0;
		code_ovf = 1'b0;
		point_count = point_count + 16'd1;
		if (blk_end) begin
			point_count = '0;
			hdr_seen = '0;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
	endtask

	// Compare one delivered sample word against the oldest expectation.
	task automatic check_sample();
		sample_t w;
		if (pending_samples.size() == 0) begin
			report_mismatch("unexpected word, sample_code", sample_out.sample_code, '0);
			return;
		end
		w = pending_samples.pop_front();
		if (sample_out.sample_code !== w.code)
			report_mismatch("sample_code", sample_out.sample_code, w.code);
		if (sample_out.point_index !== w.index)
			report_mismatch("point_index", sample_out.point_index, w.index);
		if (sample_out.voltage_value !== w.volt)
			report_mismatch("voltage_value", sample_out.voltage_value, w.volt);
		if (sample_out.time_value !== w.tval)
			report_mismatch("time_value", sample_out.time_value, w.tval);
		if (sample_out.overflow !== w.ovf)
			report_mismatch("overflow", sample_out.overflow, w.ovf);
		if (sample_out.last !== w.last)
			report_mismatch("last", sample_out.last, w.last);
	endtask

	// Watch all three channels; values are the ones held just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) apply_reg(cfg.index, cfg.data);
			if (char_in.valid && char_in.ready) decode_char(char_in.char_byte);
			if (sample_out.valid && sample_out.ready) check_sample();
		end
	end

	// Output back-pressure: after each accepted word, hold ready low for a drawn stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_out.ready <= 1'b0;
		end else begin
			if (sample_out.valid && sample_out.ready) sink_wait = draw_gap(sink_idle_on);
			if (sink_wait > 0) begin
				sample_out.ready <= 1'b0;
				sink_wait--;
			end else begin
				sample_out.ready <= 1'b1;
			end
		end
	end

	// Valid stays high between back-to-back words so it never drops and rises in one step.
	task automatic send_char(input logic [7:0] b);
		int gap;
		gap = draw_gap(src_idle_on);
		body_items++;
		if (gap > 0) begin
			char_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_in.valid <= 1'b1;
		char_in.char_byte <= b;
		@(posedge clk);
		while (!char_in.ready) @(posedge clk);
	endtask

	task automatic send_body(input logic [7:0] b);
		send_char(b);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		int gap;
		gap = draw_gap(src_idle_on);
		if (gap > 0) begin
			cfg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	// Wait until every expected sample is out and the pipeline has had time to settle.
	task automatic drain_pipeline();
		char_in.valid <= 1'b0;
		cfg.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] rand_data();
		return CFG_DATA_BITS'({$urandom, $urandom});
	endfunction

	function automatic logic [7:0] random_separator();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0) return CHAR_COMMA;
		do b = 8'($urandom_range(0, 255));
		while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NUL || b == CHAR_LF);
		return b;
	endfunction

	// Reset configuration: ten header bytes, including NUL and LF, are swallowed.
	task automatic test_default_header();
		send_char(CHAR_NUL);
		send_char(CHAR_LF);
		send_char(8'hff);
		send_char(8'h80);
		send_char(CHAR_ZERO + 8'd5);
		send_char(CHAR_COMMA);
		send_char(8'h7f);
		send_char(8'h01);
		send_char(8'h2a);
		send_char(8'h55);
		send_char(CHAR_ZERO + 8'd7);
		send_char(CHAR_LF);
		drain_pipeline();
	endtask

	// No header, extreme scaling; largest code, saturation, NUL end and empty samples.
	task automatic test_extreme_codes();
		write_reg(CFG_HEADER_SKIP, 48'd0);
		write_reg(CFG_Y_REFERENCE, 48'hffff);
		write_reg(CFG_Y_INCREMENT, 48'h8000_0000);
		write_reg(CFG_Y_ORIGIN, 48'h8000_0000_0000);
		write_reg(CFG_X_REFERENCE, 48'hffff);
		write_reg(CFG_X_INCREMENT, 48'h7fff_ffff);
		write_reg(CFG_X_ORIGIN, 48'h7fff_ffff_ffff);
		write_reg(CFG_UNUSED_INDEX, 48'hffff_ffff_ffff);
		cfg.valid <= 1'b0;
		send_char(CHAR_ZERO + 8'd6);
		send_char(CHAR_ZERO + 8'd5);
		send_char(CHAR_ZERO + 8'd5);
		send_char(CHAR_ZERO + 8'd3);
		send_char(CHAR_ZERO + 8'd5);
		send_char(CHAR_COMMA);
		repeat (5) send_char(CHAR_NINE);
		send_char(CHAR_NUL);
		send_char(CHAR_COMMA);
		send_char(CHAR_NINE + 8'd1);
		send_char(CHAR_ZERO - 8'd1);
		send_char(CHAR_LF);
		drain_pipeline();
	endtask

	// Each phase rewrites every register; the first two use the range extremes.
	task automatic program_phase(input int phase);
		case (phase)
			0: begin
				write_reg(CFG_HEADER_SKIP, 48'd0);
				write_reg(CFG_Y_REFERENCE, 48'd0);
				write_reg(CFG_Y_INCREMENT, 48'h8000_0000);
				write_reg(CFG_Y_ORIGIN, 48'h8000_0000_0000);
				write_reg(CFG_X_REFERENCE, 48'd0);
				write_reg(CFG_X_INCREMENT, 48'h8000_0000);
				write_reg(CFG_X_ORIGIN, 48'h8000_0000_0000);
			end
			1: begin
				write_reg(CFG_HEADER_SKIP, 48'hf);
				write_reg(CFG_Y_REFERENCE, 48'hffff);
				write_reg(CFG_Y_INCREMENT, 48'h7fff_ffff);
				write_reg(CFG_Y_ORIGIN, 48'h7fff_ffff_ffff);
				write_reg(CFG_X_REFERENCE, 48'hffff);
				write_reg(CFG_X_INCREMENT, 48'h7fff_ffff);
				write_reg(CFG_X_ORIGIN, 48'h7fff_ffff_ffff);
			end
			default: begin
				write_reg(CFG_HEADER_SKIP, rand_data());
				write_reg(CFG_Y_REFERENCE, rand_data());
				write_reg(CFG_Y_INCREMENT, rand_data());
				write_reg(CFG_Y_ORIGIN, rand_data());
				write_reg(CFG_X_REFERENCE, rand_data());
				write_reg(CFG_X_INCREMENT, rand_data());
				write_reg(CFG_X_ORIGIN, rand_data());
				if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED_INDEX, rand_data());
			end
		endcase
		cfg.valid <= 1'b0;
	endtask

	// One reply block: header, samples of random length, then mostly a proper terminator.
	task automatic send_block();
		int n_samples;
		int n_digits;
		src_idle_on = $urandom_range(0, 3) != 0;
		sink_idle_on = $urandom_range(0, 3) != 0;
		for (int i = 0; i < active_cfg.header_skip; i++)
			send_char(8'($urandom_range(0, 255)));
		n_samples = $urandom_range(1, 12);
		repeat (n_samples) begin
			if ($urandom_range(0, 9) == 0) begin
				send_body(8'($urandom_range(0, 255)));
			end else begin
				n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8)
					: $urandom_range(0, 5);
				repeat (n_digits) send_body(CHAR_ZERO + 8'($urandom_range(0, 9)));
				send_body(random_separator());
			end
		end
		if ($urandom_range(0, 7) != 0) send_body($urandom_range(0, 1) ? CHAR_LF : CHAR_NUL);
	endtask

	task automatic test_random_blocks();
		for (int phase = 0; phase < 5; phase++) begin
			drain_pipeline();
			program_phase(phase);
			while (body_items < 110 * (phase + 1)) send_block();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		char_in.valid = 1'b0;
		char_in.char_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		active_cfg = '0;
		active_cfg.header_skip = HEADER_SKIP_RST;
		active_cfg.y_increment = INCREMENT_RST;
		active_cfg.x_increment = INCREMENT_RST;
		hdr_seen = '0;
		code_acc = '0;
		code_ovf = 1'b0;
		point_count = '0;
		error_count = 0;
		body_items = 0;
		sink_wait = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_header();
		test_extreme_codes();
		test_random_blocks();
		drain_pipeline();

		if (error_count == 0 && pending_samples.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
